FILE: rtl/sdls_pkg.sv
// Shared types, constants and helpers for the swing display line scheduler.
package sdls_pkg;

    // Time base and item widths
    localparam int unsigned TW         = 16;
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned ROW_W      = 8;
    localparam int unsigned LINE_COUNT = 8;
    localparam int unsigned IDX_W      = $clog2(LINE_COUNT);
    localparam int unsigned FRAME_W    = LINE_COUNT * ROW_W;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 4;

    typedef logic [TW-1:0]      t_time;
    typedef logic [TW:0]        t_magic;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [FRAME_W-1:0] t_frame;

    // Register map: register index taken from paddr[3] (8-byte spacing)
    localparam logic REG_FRAME_ROWS = 1'b0;
    localparam t_frame FRAME_RESET  = 64'hF088_88F0_888C_88F0;

    // State reset values
    localparam t_time     PERIOD_RESET = t_time'(7800);
    localparam logic [1:0] DIR_RESET   = 2'd1;
    localparam logic [1:0] DIR_MAX     = 2'd2;
    localparam t_idx      LAST_IDX     = t_idx'(LINE_COUNT - 1);

    // Request codes
    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_LINE   = 2'd1,
        REQ_HALF   = 2'd2,
        REQ_IGNORE = 2'd3
    } t_req;

    // One input beat
    typedef struct packed {
        t_req                       req;
        logic signed [SAMPLE_W-1:0] sample;
        t_time                      ts;
    } t_item;

    // One result beat
    typedef struct packed {
        logic  line_valid;
        t_row  line_pattern;
        t_time line_deadline;
        logic  swing_restart;
        t_time timer_reload;
        t_time half_swing_deadline;
    } t_result;

    // Request to the line timing calculator
    typedef struct packed {
        t_time period;
        t_time base;
        t_idx  idx;
    } t_timing_req;

    // Answer from the line timing calculator
    typedef struct packed {
        t_time line_deadline;
        t_time half_deadline;
    } t_timing_rsp;

    // Reciprocal constants: m = ceil(2^(TW+l)/d), l = ceil(log2 d), exact for TW-bit x
    localparam int unsigned DIV11_SH  = TW + 4;
    localparam int unsigned DIV12_SH  = TW + 4;
    localparam int unsigned DIV50_SH  = TW + 6;
    localparam int unsigned DIV200_SH = TW + 8;
    localparam int unsigned DIV300_SH = TW + 9;
    localparam t_magic DIV11_M  = t_magic'(((64'd1 << DIV11_SH) + 64'd10) / 64'd11);
    localparam t_magic DIV12_M  = t_magic'(((64'd1 << DIV12_SH) + 64'd11) / 64'd12);
    localparam t_magic DIV50_M  = t_magic'(((64'd1 << DIV50_SH) + 64'd49) / 64'd50);
    localparam t_magic DIV200_M = t_magic'(((64'd1 << DIV200_SH) + 64'd199) / 64'd200);
    localparam t_magic DIV300_M = t_magic'(((64'd1 << DIV300_SH) + 64'd299) / 64'd300);

    // Quotient by multiply-high with a reciprocal constant
    function automatic t_time div_by_magic(input t_time x, input t_magic m,
                                           input int unsigned sh);
        logic [2*TW:0] prod;
        prod = {{(TW+1){1'b0}}, x} * {{TW{1'b0}}, m};
        return t_time'(prod >> sh);
    endfunction

endpackage

FILE: rtl/swing_display_line_scheduler_core.sv
// Top level: input register, scheduler logic and result register.
//
// Swing display line scheduler. Each input beat (accelerometer sample,
// line-timer event or half-swing-timer event) produces exactly one result
// beat, passing through the input register and then the result register. One
// beat is accepted every cycle as long as the
// result side keeps up; the only stall comes from a full result register
// while the consumer holds i_out_ready low. Direction tracking, the line
// duration divisions (reciprocal multiplies) and the deadline adds all
// settle between the input and result registers. The frame rows are a
// 64-bit APB register at address 0; write it only while no beats are in
// flight.
module swing_display_line_scheduler_core import sdls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_req_type,
    input  logic signed [7:0]     i_sample,
    input  logic [15:0]           i_timestamp,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_line_valid,
    output logic [7:0]            o_line_pattern,
    output logic [15:0]           o_line_deadline,
    output logic                  o_swing_restart,
    output logic [15:0]           o_timer_reload,
    output logic [15:0]           o_half_swing_deadline,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;

    logic    advance;
    logic    fire;
    t_frame  frame_rows;
    t_result n_result;

    // Pipeline moves when the result register is free or being drained
    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.req    <= t_req'(i_req_type);
            r_item.sample <= i_sample;
            r_item.ts     <= i_timestamp;
        end
    end

    sdls_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_frame_rows (frame_rows)
    );

    sdls_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_item),
        .i_frame_rows (frame_rows),
        .o_result     (n_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_line_valid          = r_result.line_valid;
    assign o_line_pattern        = r_result.line_pattern;
    assign o_line_deadline       = r_result.line_deadline;
    assign o_swing_restart       = r_result.swing_restart;
    assign o_timer_reload        = r_result.timer_reload;
    assign o_half_swing_deadline = r_result.half_swing_deadline;

    // A restart beat always carries the first line
    a_restart_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_swing_restart |-> o_line_valid)
        else $error("restart beat without line");

    // Input side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && o_out_valid && !i_out_ready)
        else $error("input stalled without back-pressure");

endmodule

FILE: rtl/sdls_cfg.sv
// APB configuration register holding the eight frame rows.
module sdls_cfg import sdls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_frame                o_frame_rows
);

    t_frame r_frame_rows;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[3] == REG_FRAME_ROWS);

    // Frame row register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= FRAME_RESET;
        end else if (wr_en) begin
            r_frame_rows <= pwdata;
        end
    end

    // Read mux; unused addresses read zero
    always_comb begin
        prdata = '0;
        if (paddr[3] == REG_FRAME_ROWS) begin
            prdata = r_frame_rows;
        end
    end

    assign o_frame_rows = r_frame_rows;

endmodule

FILE: rtl/sdls_timing.sv
// Line duration table by constant division and deadline adders.
module sdls_timing import sdls_pkg::*; (
    input  t_timing_req i_req,
    output t_timing_rsp o_rsp
);

    t_time q4, q8, q11, q12, q50, q200, q300;
    t_time dur;

    // Quotients of the swing period
    assign q4   = i_req.period >> 2;
    assign q8   = i_req.period >> 3;
    assign q11  = div_by_magic(i_req.period, DIV11_M, DIV11_SH);
    assign q12  = div_by_magic(i_req.period, DIV12_M, DIV12_SH);
    assign q50  = div_by_magic(i_req.period, DIV50_M, DIV50_SH);
    assign q200 = div_by_magic(i_req.period, DIV200_M, DIV200_SH);
    assign q300 = div_by_magic(i_req.period, DIV300_M, DIV300_SH);

    // Duration profile symmetric over lines 1 to 6, last line holds for a full period
    always_comb begin
        unique case (i_req.idx)
            3'd0:       dur = q4 - q50;
            3'd1, 3'd6: dur = q8 - q50;
            3'd2, 3'd5: dur = q11 - q200;
            3'd3, 3'd4: dur = q12 - q300;
            default:    dur = i_req.period;
        endcase
    end

    assign o_rsp.line_deadline = i_req.base + dur;
    assign o_rsp.half_deadline = i_req.base + (i_req.period >> 1);

endmodule

FILE: rtl/sdls_ctrl.sv
// Swing direction tracking, scheduler state and result formation.
module sdls_ctrl import sdls_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_frame  i_frame_rows,
    output t_result o_result
);

    t_time                      r_period;
    t_idx                       r_line_index;
    logic                       r_reverse_dir;
    logic [1:0]                 r_dir_count;
    logic signed [SAMPLE_W-1:0] r_prev_sample;
    t_time                      r_prev_time;
    t_time                      r_prev_prev_time;
    t_time                      r_swing_start;
    logic                       r_check_enabled;

    logic        is_sample, is_line, is_half;
    logic [1:0]  n_dir_count;
    logic        reversal;
    logic        issue;
    logic        n_reverse_dir;
    t_time       new_period;
    t_idx        next_index;
    t_timing_req tim_req;
    t_timing_rsp tim_rsp;

    assign is_sample = (i_item.req == REQ_SAMPLE) && r_check_enabled;
    assign is_line   = (i_item.req == REQ_LINE);
    assign is_half   = (i_item.req == REQ_HALF);

    // Saturating direction counter
    always_comb begin
        n_dir_count = r_dir_count;
        if (i_item.sample > r_prev_sample && r_dir_count < DIR_MAX) begin
            n_dir_count = r_dir_count + 2'd1;
        end else if (i_item.sample < r_prev_sample && r_dir_count != 2'd0) begin
            n_dir_count = r_dir_count - 2'd1;
        end
    end

    // Reversal when the counter crosses against the current direction
    assign reversal = is_sample &&
                      (r_reverse_dir ? (n_dir_count > 2'd1) : (n_dir_count < 2'd1));
    assign n_reverse_dir = r_reverse_dir ^ reversal;
    assign issue         = reversal || is_line;
    assign new_period    = r_prev_prev_time - r_swing_start;

    // Line timing: fresh period and line 0 on a reversal
    assign tim_req.period = reversal ? new_period       : r_period;
    assign tim_req.base   = reversal ? r_prev_prev_time : i_item.ts;
    assign tim_req.idx    = reversal ? '0               : r_line_index;

    sdls_timing u_timing (
        .i_req (tim_req),
        .o_rsp (tim_rsp)
    );

    assign next_index = (tim_req.idx < LAST_IDX) ? tim_req.idx + t_idx'(1) : tim_req.idx;

    // Result beat
    always_comb begin
        o_result = '0;
        if (issue) begin
            o_result.line_valid    = 1'b1;
            o_result.line_pattern  = n_reverse_dir ? '0
                                   : i_frame_rows[tim_req.idx*ROW_W +: ROW_W];
            o_result.line_deadline = tim_rsp.line_deadline;
        end
        if (reversal) begin
            o_result.swing_restart       = 1'b1;
            o_result.timer_reload        = r_prev_prev_time;
            o_result.half_swing_deadline = tim_rsp.half_deadline;
        end
    end

    // Scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period         <= PERIOD_RESET;
            r_line_index     <= '0;
            r_reverse_dir    <= 1'b0;
            r_dir_count      <= DIR_RESET;
            r_prev_sample    <= '0;
            r_prev_time      <= '0;
            r_prev_prev_time <= '0;
            r_swing_start    <= '0;
            r_check_enabled  <= 1'b0;
        end else if (i_fire) begin
            if (is_sample) begin
                r_dir_count <= n_dir_count;
                if (reversal) begin
                    r_reverse_dir   <= n_reverse_dir;
                    r_period        <= new_period;
                    r_check_enabled <= 1'b0;
                    r_swing_start   <= r_prev_prev_time;
                    r_line_index    <= next_index;
                end else begin
                    r_prev_sample    <= i_item.sample;
                    r_prev_prev_time <= r_prev_time;
                    r_prev_time      <= i_item.ts;
                end
            end else if (is_line) begin
                r_line_index <= next_index;
            end else if (is_half) begin
                r_check_enabled <= 1'b1;
            end
        end
    end

    // Checking shuts off only through a reversal
    a_check_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_check_enabled) |-> $past(i_fire && reversal))
        else $error("checking disabled without a reversal");

    // A reversal restarts the swing at the old history point, line 1 next
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && reversal |=>
        r_line_index == t_idx'(1) && r_swing_start == $past(r_prev_prev_time))
        else $error("swing restart state wrong");

    // Direction counter stays within its range
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> r_dir_count <= DIR_MAX)
        else $error("direction counter out of range");

endmodule
